// ===== rtl/core/whl_pkg.sv =====
// package for window_high_low: sizes, transaction structs and controller states
// no dependencies; compile first

package whl_pkg;

   localparam int HISTORY_DEPTH = 256;
   localparam int SAMPLE_WIDTH  = 32;
   localparam int WINDOW_WIDTH  = 9;
   localparam int PTR_WIDTH     = $clog2(HISTORY_DEPTH);
   localparam int COUNT_WIDTH   = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_WIDTH     = (COUNT_WIDTH > WINDOW_WIDTH) ? COUNT_WIDTH : WINDOW_WIDTH;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [WINDOW_WIDTH-1:0]        window_length;
      logic                           first_of_series;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] highest;
      logic signed [SAMPLE_WIDTH-1:0] lowest;
   } rsp_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_FINISH
   } state_type;

endpackage

// ===== rtl/core/window_high_low.sv =====
// window_high_low top level: sliding-window highest and lowest over a sample ring
// depends on whl_pkg and whl_ram
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | whl_pkg::req_type (sample, window, first)
//   rsp_    | out       | rsp_valid / rsp_stall  | whl_pkg::rsp_type (highest, lowest)
//
// one transaction at a time: after acceptance the older samples of the span are read
//   from the ring (a span of one skips the scan), then the result goes to the output
//   register before the next request is taken; span is the effective window
//   (1 to HISTORY_DEPTH), and the ring's single read port gives one stored sample read per cycle
// reset clears pointer, fill count and control; ring contents stay undefined until written
// a finished result waits in the output register, so the next request is taken meanwhile
// req_stall is high while a scan runs or a result is waiting to enter the output register

module window_high_low (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  whl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output whl_pkg::rsp_type rsp_data
);

   // controller state
   whl_pkg::state_type state_ff, state_in;

   // ring write pointer and number of samples stored in this series
   logic [whl_pkg::PTR_WIDTH-1:0]   wp_ff, wp_in;
   logic [whl_pkg::COUNT_WIDTH-1:0] fill_ff, fill_in;

   // scan: reads still to issue, next read address, read in flight
   logic [whl_pkg::COUNT_WIDTH-1:0] left_ff, left_in;
   logic [whl_pkg::PTR_WIDTH-1:0]   rd_addr_ff, rd_addr_in;
   logic                            pend_ff, pend_in;

   // running extremes
   logic signed [whl_pkg::SAMPLE_WIDTH-1:0] hi_ff, hi_in;
   logic signed [whl_pkg::SAMPLE_WIDTH-1:0] lo_ff, lo_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   whl_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // ring ports
   logic                                ram_wr_en;
   logic [whl_pkg::PTR_WIDTH-1:0]       ram_wr_addr;
   logic                                ram_rd_en;
   logic [whl_pkg::SAMPLE_WIDTH-1:0]    ram_rd_data;
   logic signed [whl_pkg::SAMPLE_WIDTH-1:0] rd_sample;

   // acceptance-time helpers
   logic                            req_accept;
   logic                            slot_free;
   logic [whl_pkg::PTR_WIDTH-1:0]   newest;
   logic [whl_pkg::COUNT_WIDTH-1:0] fill_new;
   logic [whl_pkg::CMP_WIDTH-1:0]   span_cmp;
   logic [whl_pkg::CMP_WIDTH-1:0]   fill_cmp;
   logic [whl_pkg::COUNT_WIDTH-1:0] span;

   whl_ram #(
      .WIDTH(whl_pkg::SAMPLE_WIDTH),
      .DEPTH(whl_pkg::HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.sample),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_sample  = $signed(ram_rd_data);
   assign req_stall  = (state_ff != whl_pkg::STATE_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // new series restarts the ring at slot zero
   assign newest   = req_data.first_of_series ? '0 : wp_ff;
   assign ram_wr_en   = req_accept;
   assign ram_wr_addr = newest;

   // fill count after this sample, saturating at the ring depth
   always_comb begin
      if (req_data.first_of_series) begin
         fill_new = whl_pkg::COUNT_WIDTH'(1);
      end else if (fill_ff == whl_pkg::COUNT_WIDTH'(whl_pkg::HISTORY_DEPTH)) begin
         fill_new = fill_ff;
      end else begin
         fill_new = fill_ff + whl_pkg::COUNT_WIDTH'(1);
      end
   end

   // zero window acts as one; clamp to the fill count, which also caps at the depth
   assign fill_cmp = whl_pkg::CMP_WIDTH'(fill_new);
   always_comb begin
      if (req_data.window_length == '0) begin
         span_cmp = whl_pkg::CMP_WIDTH'(1);
      end else begin
         span_cmp = whl_pkg::CMP_WIDTH'(req_data.window_length);
      end
      if (span_cmp > fill_cmp) begin
         span_cmp = fill_cmp;
      end
   end
   assign span = span_cmp[whl_pkg::COUNT_WIDTH-1:0];

   assign ram_rd_en = (state_ff == whl_pkg::STATE_SCAN) && (left_ff != '0);

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      left_in      = left_ff;
      rd_addr_in   = rd_addr_ff;
      pend_in      = 1'b0;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         whl_pkg::STATE_IDLE: begin
            if (req_accept) begin
               // current sample seeds both extremes; older ones come from the ring
               hi_in   = req_data.sample;
               lo_in   = req_data.sample;
               fill_in = fill_new;
               if (newest == whl_pkg::PTR_WIDTH'(whl_pkg::HISTORY_DEPTH - 1)) begin
                  wp_in = '0;
               end else begin
                  wp_in = newest + whl_pkg::PTR_WIDTH'(1);
               end
               if (newest == '0) begin
                  rd_addr_in = whl_pkg::PTR_WIDTH'(whl_pkg::HISTORY_DEPTH - 1);
               end else begin
                  rd_addr_in = newest - whl_pkg::PTR_WIDTH'(1);
               end
               left_in = span - whl_pkg::COUNT_WIDTH'(1);
               if (span == whl_pkg::COUNT_WIDTH'(1)) begin
                  state_in = whl_pkg::STATE_FINISH;
               end else begin
                  state_in = whl_pkg::STATE_SCAN;
               end
            end
         end
         whl_pkg::STATE_SCAN: begin
            // fold in the sample read last cycle
            if (pend_ff) begin
               if (rd_sample > hi_ff) begin
                  hi_in = rd_sample;
               end
               if (rd_sample < lo_ff) begin
                  lo_in = rd_sample;
               end
            end
            if (ram_rd_en) begin
               pend_in = 1'b1;
               left_in = left_ff - whl_pkg::COUNT_WIDTH'(1);
               if (rd_addr_ff == '0) begin
                  rd_addr_in = whl_pkg::PTR_WIDTH'(whl_pkg::HISTORY_DEPTH - 1);
               end else begin
                  rd_addr_in = rd_addr_ff - whl_pkg::PTR_WIDTH'(1);
               end
            end else begin
               // last read is being folded in this cycle
               state_in = whl_pkg::STATE_FINISH;
            end
         end
         whl_pkg::STATE_FINISH: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.highest = hi_ff;
               rsp_data_in.lowest  = lo_ff;
               state_in            = whl_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = whl_pkg::STATE_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= whl_pkg::STATE_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      rsp_data_ff <= rsp_data_in;
   end

   // fill count never passes the ring depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= whl_pkg::COUNT_WIDTH'(whl_pkg::HISTORY_DEPTH))
      else $error("fill count beyond ring depth");

   // a new series leaves exactly one stored sample
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.first_of_series |=> fill_ff == whl_pkg::COUNT_WIDTH'(1))
      else $error("series start did not restart fill count");

   // reads are only in flight during a scan
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == whl_pkg::STATE_SCAN))
      else $error("ring read outside scan");

   // a delivered result has highest at or above lowest
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.highest >= rsp_data_ff.lowest))
      else $error("highest below lowest");

   // outstanding reads never exceed what the fill count allows
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == whl_pkg::STATE_SCAN) |-> (left_ff < fill_ff))
      else $error("scan reaches past stored samples");

endmodule

// ===== rtl/core/whl_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies

module whl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
